// ----- rtl/core/hkrb_pkg.sv -----
// shared types and constants of the keyboard report builder
// used by hkrb_ctrl, hkrb_dp and hid_key_report_builder_top
package hkrb_pkg;

  localparam int unsigned KEY_SLOTS_DEF = 6;
  localparam int unsigned REPORT_SLOTS  = 6;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned ACTION_W      = 2;

  // modifier codes are FIRST_MODIFIER .. FIRST_MODIFIER + 7
  localparam logic [CODE_W-1:0] FIRST_MODIFIER = 8'hE0;
  localparam logic [CODE_W-1:0] EMPTY_CODE     = 8'h00;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PRESS       = 2'd0,
    ACT_RELEASE     = 2'd1,
    ACT_RELEASE_ALL = 2'd2,
    ACT_NOP         = 2'd3
  } action_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CODE_W-1:0]   key_code;
  } key_req_t;

  typedef struct packed {
    logic              accepted;
    logic [CODE_W-1:0] modifier_mask;
    logic [CODE_W-1:0] slot_zero;
    logic [CODE_W-1:0] slot_one;
    logic [CODE_W-1:0] slot_two;
    logic [CODE_W-1:0] slot_three;
    logic [CODE_W-1:0] slot_four;
    logic [CODE_W-1:0] slot_five;
  } key_rpt_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic mod_set;
    logic mod_clr;
    logic clr_all;
    logic slot_fill;
    logic reject;
    logic idx_inc;
    logic rel_step;
    logic rel_clear;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                is_mod;
    logic                hit;
    logic                empty;
    logic                last;
    logic                out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/hkrb_dp.sv -----
// datapath: request register, modifier mask, key slots, scan counters and report register
// depends on hkrb_pkg
module hkrb_dp #(
  parameter int unsigned KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hkrb_pkg::key_req_t in_req_i,
  input  hkrb_pkg::dp_cmd_t  cmd_i,
  output hkrb_pkg::dp_sts_t  sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output hkrb_pkg::key_rpt_t out_rpt_o
);
  import hkrb_pkg::*;

  localparam int unsigned IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(KEY_SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(KEY_SLOTS - 1);

  key_req_t          req_q;
  logic [CODE_W-1:0] mod_q, mod_d;
  logic [CODE_W-1:0] slot_q [KEY_SLOTS];
  logic [CODE_W-1:0] slot_d [KEY_SLOTS];
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   kept_q, kept_d;
  logic              acc_q, acc_d;
  logic              out_valid_q;
  key_rpt_t          out_rpt_q;
  logic [CODE_W-1:0] cur;
  logic              keep;
  logic [CODE_W-1:0] rep [REPORT_SLOTS];
  logic [CODE_W-1:0] mod_bit;

  assign cur     = slot_q[idx_q];
  assign keep    = (cur != req_q.key_code) && (cur != EMPTY_CODE);
  assign mod_bit = CODE_W'(1) << req_q.key_code[2:0];

  assign sts_o.action   = req_q.action;
  assign sts_o.is_mod   = (req_q.key_code[7:3] == FIRST_MODIFIER[7:3]);
  assign sts_o.hit      = (cur == req_q.key_code);
  assign sts_o.empty    = (cur == EMPTY_CODE);
  assign sts_o.last     = (idx_q == LastIdx);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mod_d  = mod_q;
    slot_d = slot_q;
    idx_d  = idx_q;
    kept_d = kept_q;
    acc_d  = acc_q;
    if (cmd_i.load_req) begin
      idx_d  = '0;
      kept_d = '0;
      acc_d  = 1'b1;
    end
    if (cmd_i.mod_set) mod_d = mod_q | mod_bit;
    if (cmd_i.mod_clr) mod_d = mod_q & ~mod_bit;
    if (cmd_i.clr_all) begin
      mod_d = '0;
      for (int j = 0; j < KEY_SLOTS; j++) slot_d[j] = EMPTY_CODE;
    end
    if (cmd_i.slot_fill && sts_o.empty) slot_d[idx_q] = req_q.key_code;
    if (cmd_i.reject) acc_d = 1'b0;
    if (cmd_i.idx_inc) idx_d = idx_q + IdxW'(1);
    // compaction writes never run ahead of the read index
    if (cmd_i.rel_step && keep) begin
      slot_d[kept_q[IdxW-1:0]] = cur;
      kept_d = kept_q + CntW'(1);
    end
    if (cmd_i.rel_clear) begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (CntW'(j) >= kept_q) slot_d[j] = EMPTY_CODE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      acc_q       <= 1'b1;
      out_valid_q <= 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) slot_q[j] <= EMPTY_CODE;
    end else begin
      mod_q  <= mod_d;
      slot_q <= slot_d;
      idx_q  <= idx_d;
      kept_q <= kept_d;
      acc_q  <= acc_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // slots beyond the configured count read as empty
  for (genvar g = 0; g < REPORT_SLOTS; g++) begin : g_rep
    if (g < KEY_SLOTS) begin : g_used
      assign rep[g] = slot_q[g];
    end else begin : g_unused
      assign rep[g] = EMPTY_CODE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= in_req_i;
    if (cmd_i.out_load) begin
      out_rpt_q.accepted      <= acc_q;
      out_rpt_q.modifier_mask <= mod_q;
      out_rpt_q.slot_zero     <= rep[0];
      out_rpt_q.slot_one      <= rep[1];
      out_rpt_q.slot_two      <= rep[2];
      out_rpt_q.slot_three    <= rep[3];
      out_rpt_q.slot_four     <= rep[4];
      out_rpt_q.slot_five     <= rep[5];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rpt_o   = out_rpt_q;

endmodule

// ----- rtl/core/hkrb_ctrl.sv -----
// controller: sequences one key event through the datapath
// depends on hkrb_pkg
module hkrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hkrb_pkg::dp_sts_t sts_i,
  output hkrb_pkg::dp_cmd_t cmd_o
);
  import hkrb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRESS_SCAN,
    ST_REL_SCAN,
    ST_REL_CLEAR,
    ST_FINISH
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: cmd_o.load_req = in_valid_i;
      ST_EXEC: begin
        unique case (action_e'(sts_i.action))
          ACT_PRESS:       cmd_o.mod_set = sts_i.is_mod;
          ACT_RELEASE:     cmd_o.mod_clr = sts_i.is_mod;
          ACT_RELEASE_ALL: cmd_o.clr_all = 1'b1;
          ACT_NOP:         cmd_o = '0;
          default:         cmd_o = '0;
        endcase
      end
      ST_PRESS_SCAN: begin
        priority if (sts_i.hit || sts_i.empty) begin
          cmd_o.slot_fill = 1'b1;
        end else if (sts_i.last) begin
          cmd_o.reject = 1'b1;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_REL_SCAN: begin
        cmd_o.rel_step = 1'b1;
        cmd_o.idx_inc  = !sts_i.last;
      end
      ST_REL_CLEAR: cmd_o.rel_clear = 1'b1;
      ST_FINISH:    cmd_o.out_load  = sts_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (action_e'(sts_i.action) == ACT_PRESS && !sts_i.is_mod) begin
            state_q <= ST_PRESS_SCAN;
          end else if (action_e'(sts_i.action) == ACT_RELEASE && !sts_i.is_mod) begin
            state_q <= ST_REL_SCAN;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_PRESS_SCAN: begin
          if (sts_i.hit || sts_i.empty || sts_i.last) state_q <= ST_FINISH;
        end
        ST_REL_SCAN: begin
          if (sts_i.last) state_q <= ST_REL_CLEAR;
        end
        ST_REL_CLEAR: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/hid_key_report_builder_top.sv -----
// Boot-keyboard report builder: each key event request (press, release, release all)
// updates an 8-bit modifier mask and KEY_SLOTS compacted key slots and returns the whole
// report with an accept flag that is low only when a press found every slot taken. One
// event is worked at a time. Modifier events, release-all and the unused action pass
// from ST_EXEC straight to ST_FINISH; a key press scans the slots up to a match or an
// empty or last slot, and a key release scans every slot and then clears the tail, one
// slot per cycle. The report is loaded once the output register is free; the next
// request can be taken in the cycle after, and also while the loaded report waits.
// depends on hkrb_pkg, hkrb_ctrl, hkrb_dp
module hid_key_report_builder_top #(
  parameter int unsigned KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hkrb_pkg::key_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hkrb_pkg::key_rpt_t out_rpt_o
);
  import hkrb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  hkrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hkrb_dp #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rpt_o   (out_rpt_o)
  );

  // in_ready_o drops once a request is accepted, while the request is worked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted on back-to-back cycles");

  // reported slots stay compacted: no code after an empty slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_rpt_o.slot_zero  != EMPTY_CODE || out_rpt_o.slot_one   == EMPTY_CODE) &&
      (out_rpt_o.slot_one   != EMPTY_CODE || out_rpt_o.slot_two   == EMPTY_CODE) &&
      (out_rpt_o.slot_two   != EMPTY_CODE || out_rpt_o.slot_three == EMPTY_CODE) &&
      (out_rpt_o.slot_three != EMPTY_CODE || out_rpt_o.slot_four  == EMPTY_CODE) &&
      (out_rpt_o.slot_four  != EMPTY_CODE || out_rpt_o.slot_five  == EMPTY_CODE))
    else $error("report slots not compacted");

  // a rejected press means every slot was full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rpt_o.accepted |->
      (KEY_SLOTS < REPORT_SLOTS) || out_rpt_o.slot_five != EMPTY_CODE)
    else $error("press rejected with a free slot");

  // at most one slot or mask update per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.mod_set, cmd.mod_clr, cmd.clr_all, cmd.slot_fill, cmd.rel_step,
              cmd.rel_clear, cmd.out_load, cmd.load_req}))
    else $error("conflicting datapath commands");

endmodule

// ----- tb/tb.sv -----
// testbench of the boot-keyboard report builder: a directed table, then random key events
// under bursty requests, stalled reports and one long report hold-off
// depends on hkrb_pkg and hid_key_report_builder_top
`timescale 1ns / 100ps

module tb;
  import hkrb_pkg::*;

  localparam int unsigned KEY_SLOTS  = KEY_SLOTS_DEF;
  localparam int          NUM_DIR    = 25;
  localparam int          RAND_ITEMS = 1800;
  localparam int          HOLD_CYCLES = 400;
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          DRAIN_CYCLES = 4 * (KEY_SLOTS + 3);
  localparam logic [CODE_W-1:0] LAST_MODIFIER = FIRST_MODIFIER + 8'd7;

  typedef struct {
    action_e           act;
    logic [CODE_W-1:0] code;
    bit                typed;
    key_rpt_t          rpt;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     out_ready_i = 1'b0;
  key_req_t in_req_i    = '0;
  logic     in_ready_o;
  logic     out_valid_o;
  key_rpt_t out_rpt_o;

  // predictor state
  logic [CODE_W-1:0] held_mods;
  logic [CODE_W-1:0] held_keys [KEY_SLOTS];

  key_rpt_t pending_reports [$];
  dir_row_t dir_rows [NUM_DIR];
  int       mismatches  = 0;
  int       unexpected  = 0;
  int       n_sent      = 0;
  int       n_checked   = 0;
  int       n_rejected  = 0;
  int       max_fill    = 0;
  bit       hold_off_req = 1'b0;
  bit       hold_off_done = 1'b0;

  hid_key_report_builder_top #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rpt_o   (out_rpt_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // updates the held report for one key event and returns the report it yields
  function automatic key_rpt_t apply_key_event(key_req_t req);
    key_rpt_t          r;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] off;
    logic [CODE_W-1:0] v;
    bit                is_mod;
    bit                done;
    int                kept;
    int                fill;
    code   = req.key_code;
    off    = code - FIRST_MODIFIER;
    is_mod = (code >= FIRST_MODIFIER) && (code <= LAST_MODIFIER);
    r      = '0;
    r.accepted = 1'b1;
    case (action_e'(req.action))
      ACT_PRESS: begin
        if (is_mod) begin
          held_mods[off[2:0]] = 1'b1;
        end else begin
          done = 1'b0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (!done) begin
              if (held_keys[i] == code) begin
                done = 1'b1;
              end else if (held_keys[i] == EMPTY_CODE) begin
                held_keys[i] = code;
                done = 1'b1;
              end
            end
          end
          r.accepted = done;
        end
      end
      ACT_RELEASE: begin
        if (is_mod) begin
          held_mods[off[2:0]] = 1'b0;
        end else begin
          // drop matching codes and close the gaps in order
          kept = 0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            v = held_keys[i];
            if (v != code && v != EMPTY_CODE) begin
              held_keys[kept] = v;
              kept++;
            end
          end
          for (int i = kept; i < KEY_SLOTS; i++) held_keys[i] = EMPTY_CODE;
        end
      end
      ACT_RELEASE_ALL: begin
        held_mods = '0;
        for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = EMPTY_CODE;
      end
      default: begin
      end
    endcase
    fill = 0;
    for (int i = 0; i < KEY_SLOTS; i++) if (held_keys[i] != EMPTY_CODE) fill++;
    if (fill > max_fill) max_fill = fill;
    r.modifier_mask = held_mods;
    r.slot_zero     = (KEY_SLOTS > 0) ? held_keys[0] : EMPTY_CODE;
    r.slot_one      = (KEY_SLOTS > 1) ? held_keys[1] : EMPTY_CODE;
    r.slot_two      = (KEY_SLOTS > 2) ? held_keys[2] : EMPTY_CODE;
    r.slot_three    = (KEY_SLOTS > 3) ? held_keys[3] : EMPTY_CODE;
    r.slot_four     = (KEY_SLOTS > 4) ? held_keys[4] : EMPTY_CODE;
    r.slot_five     = (KEY_SLOTS > 5) ? held_keys[5] : EMPTY_CODE;
    return r;
  endfunction

  // random key event, mostly presses and releases of a small set of codes
  function automatic key_req_t next_key_event();
    key_req_t req;
    int       pick;
    int       n;
    pick = $urandom_range(0, 99);
    req  = '0;
    n    = 0;
    for (int i = 0; i < KEY_SLOTS; i++) if (held_keys[i] != EMPTY_CODE) n++;
    if (pick < 48) begin
      req.action = ACT_PRESS;
      pick = $urandom_range(0, 99);
      if (pick < 68)      req.key_code = 8'h04 + 8'($urandom_range(0, 9));
      else if (pick < 84) req.key_code = FIRST_MODIFIER + 8'($urandom_range(0, 7));
      else if (pick < 95) req.key_code = 8'($urandom_range(0, 255));
      else                req.key_code = EMPTY_CODE;
    end else if (pick < 84) begin
      req.action = ACT_RELEASE;
      pick = $urandom_range(0, 99);
      if (pick < 50 && n > 0) req.key_code = held_keys[$urandom_range(0, n - 1)];
      else if (pick < 70)     req.key_code = FIRST_MODIFIER + 8'($urandom_range(0, 7));
      else if (pick < 90)     req.key_code = 8'h04 + 8'($urandom_range(0, 9));
      else                    req.key_code = 8'($urandom_range(0, 255));
    end else if (pick < 88) begin
      req.action   = ACT_RELEASE_ALL;
      req.key_code = 8'($urandom_range(0, 255));
    end else if (pick < 92) begin
      req.action   = ACT_NOP;
      req.key_code = 8'($urandom_range(0, 255));
    end else begin
      req = key_req_t'($urandom_range(0, 1023));
    end
    return req;
  endfunction

  task automatic check_field(string name, logic [CODE_W-1:0] want, logic [CODE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s in report %0d: expected %02h, got %02h", name, n_checked,
                 want, got);
    end
  endtask

  // holds the request until it is taken
  task automatic offer(key_req_t req);
    in_req_i   <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    dir_row_t  row;
    key_req_t  req;
    key_rpt_t  rpt;
    int        burst_left;
    dir_rows = '{
      '{ACT_NOP,         8'h00, 1'b1, key_rpt_t'({1'b1, 8'h00, 48'h0})},
      '{ACT_PRESS,       8'h00, 1'b1, key_rpt_t'({1'b1, 8'h00, 48'h0})},
      '{ACT_PRESS,       8'hE0, 1'b1, key_rpt_t'({1'b1, 8'h01, 48'h0})},
      '{ACT_PRESS,       8'hE7, 1'b1, key_rpt_t'({1'b1, 8'h81, 48'h0})},
      '{ACT_PRESS,       8'hE7, 1'b0, '0},
      '{ACT_RELEASE,     8'hE0, 1'b0, '0},
      '{ACT_PRESS,       8'h04, 1'b0, '0},
      '{ACT_PRESS,       8'h04, 1'b0, '0},
      '{ACT_PRESS,       8'hFF, 1'b0, '0},
      '{ACT_PRESS,       8'h01, 1'b0, '0},
      '{ACT_PRESS,       8'hDF, 1'b0, '0},
      '{ACT_PRESS,       8'hE8, 1'b0, '0},
      '{ACT_PRESS,       8'h80, 1'b0, '0},
      // full report: new code and code zero are both turned away
      '{ACT_PRESS,       8'h05, 1'b1, key_rpt_t'({1'b0, 8'h80, 48'h04FF01DFE880})},
      '{ACT_PRESS,       8'h00, 1'b1, key_rpt_t'({1'b0, 8'h80, 48'h04FF01DFE880})},
      '{ACT_PRESS,       8'h04, 1'b0, '0},
      '{ACT_RELEASE,     8'hFF, 1'b0, '0},
      '{ACT_RELEASE,     8'h77, 1'b0, '0},
      '{ACT_RELEASE,     8'h00, 1'b0, '0},
      '{ACT_RELEASE,     8'hE7, 1'b0, '0},
      '{ACT_PRESS,       8'hE3, 1'b0, '0},
      '{ACT_PRESS,       8'hAA, 1'b0, '0},
      '{ACT_RELEASE_ALL, 8'hAB, 1'b1, key_rpt_t'({1'b1, 8'h00, 48'h0})},
      '{ACT_RELEASE,     8'hE5, 1'b0, '0},
      '{ACT_NOP,         8'hFF, 1'b0, '0}
    };
    held_mods = '0;
    for (int i = 0; i < KEY_SLOTS; i++) held_keys[i] = EMPTY_CODE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst_left = $urandom_range(1, 20);
    for (int k = 0; k < NUM_DIR + RAND_ITEMS; k++) begin
      if (k < NUM_DIR) begin
        row          = dir_rows[k];
        req.action   = row.act;
        req.key_code = row.code;
      end else begin
        row.typed = 1'b0;
        req       = next_key_event();
      end
      if (k == NUM_DIR + 600) hold_off_req = 1'b1;
      offer(req);
      rpt = apply_key_event(req);
      if (!rpt.accepted) n_rejected++;
      pending_reports.push_back(row.typed ? row.rpt : rpt);
      n_sent++;
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
    in_valid_i <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d key events sent, %0d reports checked, %0d presses turned away on a full report",
             n_sent, n_checked, n_rejected);
    $display("up to %0d slots held at once, long report hold-off %s", max_fill,
             hold_off_done ? "done" : "not reached");
    if (mismatches == 0 && unexpected == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d field mismatches, %0d reports with nothing expected", mismatches,
               unexpected);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // report side stalls in changing patterns, and holds off once for a long stretch
  initial begin
    int mode;
    int span;
    int cyc;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (cyc % 3 == 0);
        endcase
        cyc++;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    key_rpt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        unexpected++;
        if (unexpected <= 10) $display("report with nothing expected: %h", out_rpt_o);
      end else begin
        want = pending_reports.pop_front();
        check_field("accepted", {7'd0, want.accepted}, {7'd0, out_rpt_o.accepted});
        check_field("modifier_mask", want.modifier_mask, out_rpt_o.modifier_mask);
        check_field("slot_zero", want.slot_zero, out_rpt_o.slot_zero);
        check_field("slot_one", want.slot_one, out_rpt_o.slot_one);
        check_field("slot_two", want.slot_two, out_rpt_o.slot_two);
        check_field("slot_three", want.slot_three, out_rpt_o.slot_three);
        check_field("slot_four", want.slot_four, out_rpt_o.slot_four);
        check_field("slot_five", want.slot_five, out_rpt_o.slot_five);
        n_checked++;
      end
    end
  end

  // watchdog: cycles in which neither channel moves a request or a report
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("timeout: no request moved for %0d cycles, %0d reports still expected",
             IDLE_LIMIT, pending_reports.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hkrb_pkg.sv
rtl/core/hkrb_dp.sv
rtl/core/hkrb_ctrl.sv
rtl/core/hid_key_report_builder_top.sv
tb/tb.sv
